FILE: rtl/core/prmd_pkg.sv
// prmd_pkg: shared types and constants of the position ramp motor drive
// holds the payload structs, controller states and the controller/datapath command bus
// no dependencies
package prmd_pkg;

    // register indexes on the configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SPEED = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_SPEED = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_END_LOW   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_END_HIGH  = 4'd3;
    localparam int CFG_DATA_BITS  = 32;

    localparam int FIELD_POS_BITS = 32;
    localparam int SPEED_BITS     = 15;
    localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET = 15'd24000;

    // control loop constants
    localparam int IDLE_BAND      = 100;
    localparam int NEAR_BAND      = 1000;
    localparam int ZERO_BAND      = 20;
    localparam int RAMP_SLOW      = 1;
    localparam int RAMP_FAST      = 100;
    localparam int RAMP_LIMIT     = 100;
    localparam int STEP_NORMAL    = 1;
    localparam int STEP_REVERSE   = 3;
    localparam int PERCENT_SCALE  = 100;
    localparam int COARSE_SHIFT   = 4;
    localparam int DUTY_SHIFT     = 3;
    localparam logic [2:0] STILL_RELOAD = 3'd3;

    // divide by 99 as multiply by ceil(2^29/99) and shift, exact below 2^22
    localparam int RECIP_SHIFT    = 29;
    localparam int RECIP_BITS     = 45;
    localparam logic [22:0] RECIP_99 = 23'd5422939;

    // quotient bits of the percent division
    localparam int PCT_QBITS      = 8;
    localparam int DIV_QW         = 8;
    localparam int DIV_CNT_BITS   = 4;

    typedef struct packed {
        logic [FIELD_POS_BITS-1:0] position;
        logic [FIELD_POS_BITS-1:0] goal;
    } in_word_t;

    typedef struct packed {
        logic [11:0]        duty_forward;
        logic [11:0]        duty_reverse;
        logic signed [7:0]  ramp_speed;
        logic [7:0]         travel_percent;
        logic [15:0]        coarse_position;
        logic [15:0]        actuations;
        logic               active;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DRV_OLD,
        ST_UPDATE,
        ST_MUL_NEW,
        ST_DRV_NEW,
        ST_FINISH,
        ST_WAIT_PCT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     recip;
        logic     div_start;
        logic     update;
        logic     mul_new;
        logic     finish;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/prmd_divider.sv
// prmd_divider: restoring divider, one quotient bit per cycle
// divisor comes pre-aligned to the top quotient bit; uses prmd_pkg
module prmd_divider #(
    parameter int DW = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [DW-1:0]                     dividend,
    input  logic [DW-1:0]                     divisor_aligned,
    input  logic [prmd_pkg::DIV_CNT_BITS-1:0] steps,
    output logic                              busy,
    output logic [prmd_pkg::DIV_QW-1:0]       quotient
);
    import prmd_pkg::*;

    logic [DW-1:0]           rem_reg, rem_next;
    logic [DW-1:0]           dsh_reg, dsh_next;
    logic [DIV_QW-1:0]       q_reg, q_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    take;

    always_comb begin
        take      = rem_reg >= dsh_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = divisor_aligned;
            q_next    = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (take) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next    = {q_reg[DIV_QW-2:0], take};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/core/prmd_datapath.sv
// prmd_datapath: loop state, configuration registers, interpolation and output register
// driven by cmd_t from prmd_ctrl; uses prmd_pkg and prmd_divider
module prmd_datapath #(
    parameter int PW = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  prmd_pkg::in_word_t                  s_data,
    input  logic                                cfg_we,
    input  logic [prmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prmd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  prmd_pkg::cmd_t                      cmd,
    output prmd_pkg::status_t                   status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output prmd_pkg::out_word_t                 m_data
);
    import prmd_pkg::*;

    localparam int DW = PW + 8;
    localparam int NW = PW + 7;

    // configuration
    logic [SPEED_BITS-1:0] min_reg, max_reg;
    logic [PW-1:0]         end_low_reg, end_high_reg;

    // loop state
    logic [PW-1:0]     pos_reg, goal_reg, prev_pos_reg, prev_goal_reg;
    logic signed [7:0] ramp_reg, ramp_next;
    logic [2:0]        still_reg, still_next;
    logic              running_reg, running_next;
    logic [15:0]       starts_reg;

    // per tick work registers
    logic [PW-1:0]         offset_reg, span_reg;
    logic [NW-1:0]         scaled_reg;
    logic [21:0]           prod_reg;
    logic [SPEED_BITS-1:0] drive_q_reg;
    logic                  lt20_reg, lt100_reg, lt1000_reg, pos_lt_goal_reg;
    logic                  old_zero_reg, loop_ran_reg;
    logic [SPEED_BITS-1:0] mag_reg;

    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    // divider
    logic                    div_busy;
    logic [DIV_QW-1:0]       div_q;
    logic [DW-1:0]           div_dividend, div_divisor;
    logic [DIV_CNT_BITS-1:0] div_steps;

    // combinational helpers
    logic [PW-1:0]         pos_in, goal_in, diff;
    logic [SPEED_BITS-1:0] range;
    logic [7:0]            ramp_neg;
    logic [6:0]            ramp_mag;
    logic                  moved, goal_changed, run_eff, old_zero;
    logic [2:0]            still_eff;
    logic signed [8:0]     ramp_ext, desired, step, ramp_calc;
    logic [SPEED_BITS:0]   drive_sum;
    logic [SPEED_BITS-1:0] new_mag;
    logic                  pct_sat;
    logic [7:0]            pct;
    logic [PW+15:0]        coarse_ext;
    logic [15:0]           coarse;

    assign pos_in  = s_data.position[PW-1:0];
    assign goal_in = s_data.goal[PW-1:0];
    assign diff    = (pos_reg > goal_reg) ? pos_reg - goal_reg : goal_reg - pos_reg;
    assign range   = (max_reg >= min_reg) ? max_reg - min_reg : '0;
    assign ramp_neg = -ramp_reg;
    assign ramp_mag = ramp_reg[7] ? ramp_neg[6:0] : ramp_reg[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '0;
            max_reg      <= MAX_SPEED_RESET;
            end_low_reg  <= '0;
            end_high_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_SPEED: min_reg      <= cfg_data[SPEED_BITS-1:0];
                CFG_MAX_SPEED: max_reg      <= cfg_data[SPEED_BITS-1:0];
                CFG_END_LOW:   end_low_reg  <= cfg_data[PW-1:0];
                CFG_END_HIGH:  end_high_reg <= cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // divider: travel percent by the span
    assign div_dividend = DW'(scaled_reg);
    assign div_divisor  = DW'(span_reg) << (PCT_QBITS - 1);
    assign div_steps    = DIV_CNT_BITS'(PCT_QBITS);

    prmd_divider #(.DW(DW)) u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (cmd.div_start),
        .dividend        (div_dividend),
        .divisor_aligned (div_divisor),
        .steps           (div_steps),
        .busy            (div_busy),
        .quotient        (div_q)
    );

    // loop update
    always_comb begin
        moved        = pos_reg != prev_pos_reg;
        goal_changed = goal_reg != prev_goal_reg;
        run_eff      = running_reg || moved || goal_changed;
        still_eff    = (moved || (!running_reg && goal_changed)) ? STILL_RELOAD : still_reg;
        old_zero     = (ramp_reg == 8'sd0) || (min_reg == '0 && drive_q_reg == '0);

        ramp_ext  = 9'(ramp_reg);
        desired   = lt1000_reg ? 9'(RAMP_SLOW) : 9'(RAMP_FAST);
        if (!pos_lt_goal_reg) begin
            desired = -desired;
        end
        step      = (!pos_lt_goal_reg != ramp_reg[7]) ? 9'(STEP_REVERSE) : 9'(STEP_NORMAL);
        ramp_calc = ramp_ext;
        if (lt20_reg) begin
            ramp_calc = '0;
        end else if (desired > ramp_ext) begin
            ramp_calc = ramp_ext + step;
        end else if (desired < ramp_ext) begin
            ramp_calc = ramp_ext - step;
        end
        if (ramp_calc > 9'(RAMP_LIMIT)) begin
            ramp_calc = 9'(RAMP_LIMIT);
        end else if (ramp_calc < -9'(RAMP_LIMIT)) begin
            ramp_calc = -9'(RAMP_LIMIT);
        end

        ramp_next    = ramp_reg;
        still_next   = still_reg;
        running_next = running_reg;
        if (run_eff) begin
            if (lt100_reg && old_zero) begin
                running_next = 1'b0;
                still_next   = still_eff;
            end else begin
                ramp_next = ramp_calc[7:0];
                if (still_eff == '0) begin
                    running_next = 1'b0;
                    still_next   = still_eff;
                end else begin
                    running_next = 1'b1;
                    still_next   = still_eff - 1'b1;
                end
            end
        end
    end

    assign drive_sum = {1'b0, min_reg} + {1'b0, drive_q_reg};
    assign new_mag   = (ramp_reg == 8'sd0) ? '0 : drive_sum[SPEED_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg  <= '0;
            prev_goal_reg <= '0;
            ramp_reg      <= '0;
            still_reg     <= '0;
            running_reg   <= 1'b0;
            starts_reg    <= '0;
        end else begin
            if (cmd.update) begin
                prev_pos_reg  <= pos_reg;
                prev_goal_reg <= goal_reg;
                ramp_reg      <= ramp_next;
                still_reg     <= still_next;
                running_reg   <= running_next;
            end
            if (cmd.finish && loop_ran_reg && old_zero_reg && new_mag != '0) begin
                starts_reg <= starts_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg  <= pos_in;
            goal_reg <= goal_in;
        end
        if (cmd.prep) begin
            offset_reg      <= (pos_reg > end_low_reg) ? pos_reg - end_low_reg : '0;
            span_reg        <= (end_high_reg > end_low_reg) ? end_high_reg - end_low_reg : '0;
            lt20_reg        <= diff < PW'(ZERO_BAND);
            lt100_reg       <= diff < PW'(IDLE_BAND);
            lt1000_reg      <= diff < PW'(NEAR_BAND);
            pos_lt_goal_reg <= pos_reg < goal_reg;
        end
        // scale after the offset register, and the interpolation quotient by 99
        if (cmd.recip) begin
            scaled_reg  <= NW'(offset_reg) * NW'(PERCENT_SCALE);
            drive_q_reg <= SPEED_BITS'((RECIP_BITS'(prod_reg) * RECIP_BITS'(RECIP_99))
                                       >> RECIP_SHIFT);
        end
        if (cmd.prep || cmd.mul_new) begin
            prod_reg <= 22'(ramp_mag - 7'd1) * 22'(range);
        end
        if (cmd.update) begin
            old_zero_reg <= old_zero;
            loop_ran_reg <= run_eff && !(lt100_reg && old_zero);
        end
        if (cmd.finish) begin
            mag_reg <= new_mag;
        end
    end

    // output word
    assign pct_sat    = (PW + 8)'(scaled_reg) >= {span_reg, 8'b0};
    assign pct        = (span_reg == '0) ? 8'd0 : (pct_sat ? 8'hFF : div_q[7:0]);
    assign coarse_ext = {16'b0, offset_reg} >> COARSE_SHIFT;
    assign coarse     = (|coarse_ext[PW+15:16]) ? 16'hFFFF : coarse_ext[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.duty_forward    <= (ramp_reg > 8'sd0) ? mag_reg[SPEED_BITS-1:DUTY_SHIFT]
                                                             : 12'd0;
            m_data_reg.duty_reverse    <= (ramp_reg < 8'sd0) ? mag_reg[SPEED_BITS-1:DUTY_SHIFT]
                                                             : 12'd0;
            m_data_reg.ramp_speed      <= ramp_reg;
            m_data_reg.travel_percent  <= pct;
            m_data_reg.coarse_position <= coarse;
            m_data_reg.actuations      <= starts_reg;
            m_data_reg.active          <= running_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

FILE: rtl/core/prmd_ctrl.sv
// prmd_ctrl: tick sequencer of the position ramp motor drive
// issues cmd_t to prmd_datapath and waits on status_t; uses prmd_pkg
module prmd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  prmd_pkg::status_t status,
    output prmd_pkg::cmd_t    cmd
);
    import prmd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DRV_OLD;
            end
            ST_DRV_OLD: begin
                cmd.recip  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                cmd.mul_new = 1'b1;
                state_next  = ST_DRV_NEW;
            end
            ST_DRV_NEW: begin
                cmd.recip  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish    = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_PCT;
            end
            ST_WAIT_PCT: begin
                if (!status.div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/position_ramp_motor_drive.sv
// position_ramp_motor_drive: closed-loop position drive with speed ramp and PWM duties
// top level; joins prmd_ctrl and prmd_datapath, uses prmd_pkg
//
//   channel  | ports                               | carries
//   ---------+-------------------------------------+-------------------------------------
//   input    | s_valid  s_ready  s_data            | one control tick: position, goal
//   result   | m_valid  m_ready  m_data            | duties, ramp, percent, coarse, counts
//   config   | cfg_valid cfg_ready cfg_index cfg_data | min/max speed, travel ends
//
// a tick goes from accept to result load, waiting in ST_DONE while the output is not free:
// the drive of the old and new ramp by a registered reciprocal multiply each, and
// an 8-step percent division in the restoring divider, plus the sequencing steps
// the next word can be taken the cycle after the load
// reset (aresetn low, synchronous) idles the loop, clears the ramp and counts
// and loads the register defaults; a stalled m_ready holds the result word
module position_ramp_motor_drive #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  prmd_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output prmd_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prmd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import prmd_pkg::*;

    // positions never exceed the 32-bit fields
    localparam int PW = (POSITION_BITS < FIELD_POS_BITS) ? POSITION_BITS : FIELD_POS_BITS;

    cmd_t    cmd;
    status_t status;

    // registers are to change only between ticks, which the block itself does not enforce; writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: one state per step of the tick
    prmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // loop state, divider and output register
    prmd_datapath #(.PW(PW)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef ASSERT_OFF
    // a started division must show busy on the next cycle
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> status.div_busy)
        else $error("divider not busy after start");

    // a result is loaded only into a free output slot
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a waiting word");

    // ramp stays within its limits
    a_ramp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.ramp_speed <= 8'sd100 && m_data.ramp_speed >= -8'sd100))
        else $error("ramp speed out of range");

    // at most one bridge leg is driven
    a_one_leg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.duty_forward == '0 || m_data.duty_reverse == '0))
        else $error("both bridge legs driven");
`endif

endmodule
